FILE: hw/rtl/mri_pkg.sv
// package for the motor resistance identifier: payload structs, register
// indexes and the controller/datapath command and status structs
`timescale 1ns / 1ps
package mri_pkg;
	localparam int VALUE_BITS = 24;
	localparam int COUNT_BITS = 16;
	localparam int CFG_BITS   = 23;
	localparam int IDX_BITS   = 3;

	localparam logic [IDX_BITS-1:0] REG_START_VOLTAGE  = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_START_TICKS    = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_HOLD_TICKS     = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_RAMP_STEP      = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_CURRENT_TARGET = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_FILTER_GAIN    = 3'd5;

	localparam logic [2:0] PH_INIT   = 3'd0;
	localparam logic [2:0] PH_WAIT   = 3'd1;
	localparam logic [2:0] PH_RAMP   = 3'd2;
	localparam logic [2:0] PH_HFULL  = 3'd3;
	localparam logic [2:0] PH_REDUCE = 3'd4;
	localparam logic [2:0] PH_HHALF  = 3'd5;
	localparam logic [2:0] PH_CALC   = 3'd6;
	localparam logic [2:0] PH_DONE   = 3'd7;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] current_alpha;
		logic signed [VALUE_BITS-1:0] current_beta;
		logic signed [VALUE_BITS-1:0] measured_d_voltage;
	} mri_in_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] d_voltage_command;
		logic                         neutral_drive;
		logic                         finished;
		logic signed [VALUE_BITS-1:0] resistance;
		logic                         divide_fault;
		logic [2:0]                   phase_code;
	} mri_out_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture input, start magnitude and filter work
		logic sqrt_step;  // one root bit
		logic mul_a;      // square alpha
		logic mul_b;      // square beta
		logic filt_i0;    // current filter: product x*g
		logic filt_i1;    // current filter: product y*(1-g), sum
		logic filt_v0;
		logic filt_v1;
		logic seq;        // run phase update
		logic div_start;
		logic div_step;
		logic div_end;
	} mri_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] phase;
	} mri_sts_t;
endpackage

FILE: hw/rtl/motor_resistance_identifier.sv
// top level of the stator resistance identifier
// depends on mri_pkg, mri_controller, mri_datapath
`timescale 1ns / 1ps
// One request per control tick, handled one at a time. On an ordinary tick the
// request passes through the two squares, a 24-step bit-serial root, four
// filter multiplies, the phase update and the result register, and the next
// request can be taken once the result register is loaded. On the calc tick a
// 41-step restoring divider plus its start and end states comes between the
// phase update and the result register. The result register parts the two
// channels: the next request is taken while a result waits, and it stops at
// its phase update until that result has been taken, so a stalled result adds
// its stall time past that point.
module motor_resistance_identifier import mri_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mri_in_t             in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output mri_out_t            out_data,
	input  logic                cfg_we,
	input  logic [IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data
);
	mri_cmd_t cmd;
	mri_sts_t sts;

	// sequencing of one request
	mri_controller u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.sts, .cmd
	);

	// arithmetic and phase registers
	mri_datapath u_dp (
		.clk, .arst_n, .in_item(in_data), .cmd, .cfg_we,
		.cfg_idx(cfg_index), .cfg_data, .sts, .result(out_data)
	);
endmodule

FILE: hw/rtl/mri_datapath.sv
// datapath: squares, bit-serial root, filters, sequence registers, serial divider
// depends on mri_pkg
`timescale 1ns / 1ps
module mri_datapath import mri_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mri_in_t               in_item,
	input  mri_cmd_t              cmd,
	input  logic                  cfg_we,
	input  logic [IDX_BITS-1:0]   cfg_idx,
	input  logic [CFG_BITS-1:0]   cfg_data,
	output mri_sts_t              sts,
	output mri_out_t              result
);
	localparam int VB = VALUE_BITS;
	localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
	localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};
	localparam int SQ = 2 * VB;          // sum of squares width (unsigned)
	localparam int DW = VB + 17;         // dividend magnitude width

	logic [22:0] start_voltage_q, current_target_q;
	logic [15:0] start_ticks_q, hold_ticks_q, ramp_step_q;
	logic [16:0] gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_voltage_q  <= 23'd131072;
			start_ticks_q    <= 16'd4000;
			hold_ticks_q     <= 16'd4000;
			ramp_step_q      <= 16'd66;
			current_target_q <= 23'd65536;
			gain_q           <= 17'd3277;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_START_VOLTAGE:  start_voltage_q  <= cfg_data;
				REG_START_TICKS:    start_ticks_q    <= cfg_data[15:0];
				REG_HOLD_TICKS:     hold_ticks_q     <= cfg_data[15:0];
				REG_RAMP_STEP:      ramp_step_q      <= cfg_data[15:0];
				REG_CURRENT_TARGET: current_target_q <= cfg_data;
				REG_FILTER_GAIN:    gain_q           <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	logic [16:0] g;
	assign g = (gain_q > 17'd65536) ? 17'd65536 : gain_q;

	// input capture and squares, one shared multiplier
	logic signed [VB-1:0] a_q, b_q, vm_q;
	logic [SQ-1:0] sumsq_q;
	logic signed [VB-1:0] sq_op;
	logic signed [SQ-1:0] sq_w;
	always_comb begin
		sq_op = cmd.mul_a ? a_q : b_q;
		sq_w  = sq_op * sq_op;
	end
	// sumsq shifts left by two per root step
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= in_item.current_alpha;
			b_q <= in_item.current_beta;
			vm_q <= in_item.measured_d_voltage;
			sumsq_q <= '0;
		end else if (cmd.mul_a) begin
			sumsq_q <= $unsigned(sq_w);
		end else if (cmd.mul_b) begin
			sumsq_q <= sumsq_q + $unsigned(sq_w);
		end else if (cmd.sqrt_step) begin
			sumsq_q <= sumsq_q << 2;
		end
	end

	// restoring root, one result bit per step
	logic [SQ-1:0] rem_q;
	logic [VB:0]   root_q;
	logic [SQ+1:0] rem_sh;
	logic [SQ+1:0] trial;
	always_comb begin
		rem_sh = {rem_q, sumsq_q[SQ-1 -: 2]};
		trial  = {{(SQ-VB-1){1'b0}}, root_q, 2'b01};
	end
	always_ff @(posedge clk) begin
		if (cmd.load || cmd.mul_a) begin
			rem_q <= '0; root_q <= '0;
		end else if (cmd.sqrt_step) begin
			if (rem_sh >= trial) begin
				rem_q  <= SQ'(rem_sh - trial);
				root_q <= {root_q[VB-1:0], 1'b1};
			end else begin
				rem_q  <= SQ'(rem_sh);
				root_q <= {root_q[VB-1:0], 1'b0};
			end
		end
	end
	logic signed [VB-1:0] mag;
	assign mag = (root_q > (VB+1)'(VMAX)) ? VMAX : VB'(root_q);

	// filters: two multiplies per filter, one per cycle
	localparam int PW = VB + 19;
	logic signed [VB-1:0] filt_i_q, filt_v_q;
	logic signed [PW-1:0] acc_q;
	logic signed [VB-1:0] fx, fy;
	logic signed [17:0]   gs, gc;
	logic signed [PW-1:0] prod_x, prod_y, fsum;
	logic signed [PW-1:0] fl;
	logic signed [VB-1:0] fsat;
	always_comb begin
		fx = cmd.filt_i0 ? mag : vm_q;
		fy = cmd.filt_i1 ? filt_i_q : filt_v_q;
		gs = $signed({1'b0, g});
		gc = $signed({1'b0, 17'd65536 - g});
		prod_x = fx * gs;
		prod_y = fy * gc;
		fsum = acc_q + prod_y + PW'(32768);
		fl   = fsum >>> 16;
		if (fl > PW'(VMAX)) fsat = VMAX;
		else if (fl < PW'(VMIN)) fsat = VMIN;
		else fsat = VB'(fl);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_i_q <= '0; filt_v_q <= '0;
		end else begin
			if (cmd.filt_i1) filt_i_q <= fsat;
			if (cmd.filt_v1) filt_v_q <= fsat;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.filt_i0 || cmd.filt_v0) acc_q <= prod_x;
	end

	// sequence state
	logic [2:0] phase_q;
	logic [COUNT_BITS-1:0] tick_q;
	logic signed [VB-1:0] drive_q, fi_q, fv_q, hi_q, hv_q, res_q;
	logic fault_q;
	mri_out_t out_q;
	logic [COUNT_BITS-1:0] tick_inc;
	logic signed [VB:0] ramp_sum;
	logic signed [VB-1:0] ramp_next, cmd_v;
	logic done_w;
	logic count_ok;
	logic [15:0] limit;
	always_comb begin
		tick_inc = (tick_q == {COUNT_BITS{1'b1}}) ? tick_q : tick_q + 1'b1;
		limit    = (phase_q == PH_INIT) ? start_ticks_q : hold_ticks_q;
		count_ok = 32'(tick_inc) >= 32'(limit);
		ramp_sum = (VB+1)'(drive_q) + $signed({{(VB-15){1'b0}}, ramp_step_q});
		ramp_next = (ramp_sum > (VB+1)'(VMAX)) ? VMAX : VB'(ramp_sum);
		// command shown for this tick
		done_w = 1'b0;
		case (phase_q)
			PH_INIT:   cmd_v = count_ok ? '0 : VB'(start_voltage_q);
			PH_RAMP:   cmd_v = ramp_next;
			PH_REDUCE: cmd_v = fv_q >>> 1;
			PH_DONE: begin
				cmd_v  = '0;
				done_w = 1'b1;
			end
			default:   cmd_v = drive_q;
		endcase
	end

	// serial signed divider on magnitudes
	logic [DW-1:0] dq_q;       // dividend shifting into quotient
	logic [VB:0]   dr_q;       // divisor magnitude
	logic [VB+1:0] drem_q;
	logic          dneg_q;
	logic signed [VB:0] dv_w, di_w;
	logic [VB+1:0] drem_sh;
	logic [DW:0]   qmag;
	always_comb begin
		dv_w = (VB+1)'(fv_q) - (VB+1)'(hv_q);
		di_w = (VB+1)'(fi_q) - (VB+1)'(hi_q);
		drem_sh = {drem_q[VB:0], dq_q[DW-1]};
		qmag = {1'b0, dq_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_INIT; tick_q <= '0; drive_q <= '0;
			fi_q <= '0; fv_q <= '0; hi_q <= '0; hv_q <= '0;
			res_q <= '0; fault_q <= 1'b0; out_q <= '0;
		end else begin
			if (cmd.seq) begin
				out_q.phase_code        <= phase_q;
				out_q.neutral_drive     <= done_w;
				out_q.finished          <= done_w;
				out_q.d_voltage_command <= cmd_v;
				case (phase_q)
					PH_INIT: begin
						if (count_ok) begin
							tick_q <= '0; drive_q <= '0; phase_q <= PH_WAIT;
						end else begin
							tick_q <= tick_inc; drive_q <= VB'(start_voltage_q);
						end
					end
					PH_WAIT: begin
						tick_q <= count_ok ? '0 : tick_inc;
						if (count_ok) phase_q <= PH_RAMP;
					end
					PH_RAMP: begin
						drive_q <= ramp_next;
						if (filt_i_q >= $signed({1'b0, current_target_q}))
							phase_q <= PH_HFULL;
					end
					PH_HFULL, PH_HHALF: begin
						tick_q <= count_ok ? '0 : tick_inc;
						if (count_ok) begin
							if (phase_q == PH_HFULL) begin
								fi_q <= filt_i_q; fv_q <= filt_v_q; phase_q <= PH_REDUCE;
							end else begin
								hi_q <= filt_i_q; hv_q <= filt_v_q; phase_q <= PH_CALC;
							end
						end
					end
					PH_REDUCE: begin
						drive_q <= fv_q >>> 1;
						phase_q <= PH_HHALF;
					end
					PH_CALC: begin
						phase_q <= PH_DONE;
					end
					default: begin
						phase_q <= PH_INIT;
					end
				endcase
			end
			if (cmd.div_end) begin
				if (di_w == '0) begin
					res_q <= '0; fault_q <= 1'b1;
				end else begin
					fault_q <= 1'b0;
					if (dneg_q) begin
						res_q <= (qmag > (DW+1)'(VMAX) + 1) ? VMIN
							: VB'(-$signed(qmag));
					end else begin
						res_q <= (qmag > (DW+1)'(VMAX)) ? VMAX : VB'(qmag);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dq_q   <= DW'(dv_w[VB] ? -dv_w : dv_w) << 16;
			dr_q   <= di_w[VB] ? (VB+1)'(-di_w) : (VB+1)'(di_w);
			drem_q <= '0;
			dneg_q <= dv_w[VB] ^ di_w[VB];
		end else if (cmd.div_step) begin
			if (drem_sh >= {1'b0, dr_q}) begin
				drem_q <= drem_sh - {1'b0, dr_q};
				dq_q   <= {dq_q[DW-2:0], 1'b1};
			end else begin
				drem_q <= drem_sh;
				dq_q   <= {dq_q[DW-2:0], 1'b0};
			end
		end
	end

	assign sts.phase = phase_q;
	always_comb begin
		result = out_q;
		result.resistance   = res_q;
		result.divide_fault = fault_q;
	end
endmodule

FILE: hw/rtl/mri_controller.sv
// controller: sequences one request through squares, root, filters, phase
// update and, in the calc phase, the divider. depends on mri_pkg
`timescale 1ns / 1ps
module mri_controller import mri_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  mri_sts_t sts,
	output mri_cmd_t cmd
);
	localparam int DSTEPS = VALUE_BITS + 17;
	typedef enum logic [3:0] {
		S_IDLE, S_MA, S_MB, S_ROOT, S_FI0, S_FI1, S_FV0, S_FV1,
		S_SEQ, S_DSTART, S_DIV, S_DEND, S_OUT
	} state_t;
	state_t state_q;
	logic [5:0] cnt_q;
	logic       calc_q;

	assign in_stall  = (state_q != S_IDLE);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; cnt_q <= '0; calc_q <= 1'b0; out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid && !in_stall) state_q <= S_MA;
				S_MA: state_q <= S_MB;
				S_MB: begin state_q <= S_ROOT; cnt_q <= '0; end
				S_ROOT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'(VALUE_BITS - 1)) state_q <= S_FI0;
				end
				S_FI0: state_q <= S_FI1;
				S_FI1: state_q <= S_FV0;
				S_FV0: state_q <= S_FV1;
				S_FV1: state_q <= S_SEQ;
				// wait here while the previous result is still held
				S_SEQ: if (!out_valid) begin
					calc_q <= (sts.phase == PH_CALC);
					state_q <= (sts.phase == PH_CALC) ? S_DSTART : S_OUT;
				end
				S_DSTART: begin state_q <= S_DIV; cnt_q <= '0; end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'(DSTEPS - 1)) state_q <= S_DEND;
				end
				S_DEND: state_q <= S_OUT;
				S_OUT: begin out_valid <= 1'b1; state_q <= S_IDLE; end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.load      = (state_q == S_IDLE) && in_valid && !in_stall;
		cmd.mul_a     = (state_q == S_MA);
		cmd.mul_b     = (state_q == S_MB);
		cmd.sqrt_step = (state_q == S_ROOT);
		cmd.filt_i0   = (state_q == S_FI0);
		cmd.filt_i1   = (state_q == S_FI1);
		cmd.filt_v0   = (state_q == S_FV0);
		cmd.filt_v1   = (state_q == S_FV1);
		cmd.seq       = (state_q == S_SEQ) && !out_valid;
		cmd.div_start = (state_q == S_DSTART);
		cmd.div_step  = (state_q == S_DIV);
		cmd.div_end   = (state_q == S_DEND) && calc_q;
	end
endmodule

FILE: hw/rtl/mri_checker.sv
// port-level checker for the resistance identifier, bound to the top level
// depends on mri_pkg
`timescale 1ns / 1ps
module mri_checker import mri_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     out_valid,
	input logic     out_stall,
	input mri_out_t out_data
);
	// done flags travel together
	a_done_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.finished == out_data.neutral_drive))
		else $error("finished and neutral_drive differ");
	// done result carries no drive
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.finished) |-> (out_data.d_voltage_command == '0))
		else $error("nonzero command on done");
	// zero divisor leaves no resistance
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.divide_fault) |-> (out_data.resistance == '0))
		else $error("resistance nonzero with divide fault");
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");
endmodule

bind motor_resistance_identifier mri_checker u_mri_checker (
	.clk, .arst_n, .out_valid, .out_stall, .out_data
);

FILE: test/motor_resistance_identifier_tb.sv
// testbench for motor_resistance_identifier: drives control ticks through the
// valid/stall channels and compares every result with a built-in predictor
// depends on mri_pkg and the motor_resistance_identifier rtl
`timescale 1ns / 1ps

// scoreboard: holds a copy of the identifier state, predicts each tick's result
// and checks what the block hands back
class tick_scoreboard;
	localparam longint VMAX = 64'sd8388607;
	localparam longint VMIN = -64'sd8388608;
	localparam longint CMAX = 65535;

	// configuration copy
	longint start_voltage, start_ticks, hold_ticks, ramp_step, current_target, filter_gain;
	// state copy
	logic [2:0] phase;
	longint tick_count, filt_i, filt_v, drive_v;
	longint full_i, full_v, half_i, half_v, r_hold;
	bit fault_hold;

	mri_pkg::mri_out_t pending[$];
	int errors;
	int checked;
	int done_count;
	int fault_count;

	function new();
		reset();
		errors = 0;
		checked = 0;
		done_count = 0;
		fault_count = 0;
	endfunction

	function void reset();
		start_voltage = 131072; start_ticks = 4000; hold_ticks = 4000;
		ramp_step = 66; current_target = 65536; filter_gain = 3277;
		phase = mri_pkg::PH_INIT; tick_count = 0;
		filt_i = 0; filt_v = 0; drive_v = 0;
		full_i = 0; full_v = 0; half_i = 0; half_v = 0;
		r_hold = 0; fault_hold = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [22:0] val);
		case (idx)
			mri_pkg::REG_START_VOLTAGE:  start_voltage  = val;
			mri_pkg::REG_START_TICKS:    start_ticks    = val[15:0];
			mri_pkg::REG_HOLD_TICKS:     hold_ticks     = val[15:0];
			mri_pkg::REG_RAMP_STEP:      ramp_step      = val[15:0];
			mri_pkg::REG_CURRENT_TARGET: current_target = val;
			mri_pkg::REG_FILTER_GAIN:    filter_gain    = val[16:0];
			default: ;
		endcase
	endfunction

	function longint clamp(longint v);
		if (v > VMAX) return VMAX;
		if (v < VMIN) return VMIN;
		return v;
	endfunction

	// rounded low-pass, floor of the Q.16 sum
	function longint smooth(longint x, longint y);
		longint g, t;
		g = (filter_gain > 65536) ? 65536 : filter_gain;
		t = x * g + y * (65536 - g) + 32768;
		return clamp(t >>> 16);
	endfunction

	function longint root(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// saturating tick counter; true once the limit is reached
	function bit count_hit(longint limit);
		if (tick_count < CMAX) tick_count++;
		if (tick_count >= limit) begin
			tick_count = 0;
			return 1;
		end
		return 0;
	endfunction

	function void note_request(mri_pkg::mri_in_t req);
		longint a, b, vm, mag, dv, di;
		mri_pkg::mri_out_t res;
		logic [2:0] code;
		bit done;
		a = req.current_alpha;
		b = req.current_beta;
		vm = req.measured_d_voltage;
		mag = root(a * a + b * b);
		if (mag > VMAX) mag = VMAX;
		code = phase;
		done = 0;
		filt_i = smooth(mag, filt_i);
		filt_v = smooth(vm, filt_v);
		case (code)
			mri_pkg::PH_INIT: begin
				drive_v = clamp(start_voltage);
				if (count_hit(start_ticks)) begin
					drive_v = 0;
					phase = mri_pkg::PH_WAIT;
				end
			end
			mri_pkg::PH_WAIT: if (count_hit(hold_ticks)) phase = mri_pkg::PH_RAMP;
			mri_pkg::PH_RAMP: begin
				drive_v = clamp(drive_v + ramp_step);
				if (filt_i >= current_target) phase = mri_pkg::PH_HFULL;
			end
			mri_pkg::PH_HFULL: if (count_hit(hold_ticks)) begin
				full_i = filt_i;
				full_v = filt_v;
				phase = mri_pkg::PH_REDUCE;
			end
			mri_pkg::PH_REDUCE: begin
				drive_v = full_v >>> 1;
				phase = mri_pkg::PH_HHALF;
			end
			mri_pkg::PH_HHALF: if (count_hit(hold_ticks)) begin
				half_i = filt_i;
				half_v = filt_v;
				phase = mri_pkg::PH_CALC;
			end
			mri_pkg::PH_CALC: begin
				dv = full_v - half_v;
				di = full_i - half_i;
				if (di == 0) begin
					r_hold = 0;
					fault_hold = 1;
					fault_count++;
				end else begin
					r_hold = clamp((dv * 65536) / di);
					fault_hold = 0;
				end
				phase = mri_pkg::PH_DONE;
			end
			default: begin
				done = 1;
				done_count++;
				phase = mri_pkg::PH_INIT;
			end
		endcase
		res.d_voltage_command = done ? '0 : drive_v[23:0];
		res.neutral_drive = done;
		res.finished = done;
		res.resistance = r_hold[23:0];
		res.divide_fault = fault_hold;
		res.phase_code = code;
		pending.push_back(res);
	endfunction

	task report(string what, longint got, longint want);
		$display("mismatch on result %0d: %s got %0d expected %0d", checked, what, got, want);
		errors++;
	endtask

	task check_result(mri_pkg::mri_out_t got);
		mri_pkg::mri_out_t want;
		if (pending.size() == 0) begin
			$display("result with no request waiting");
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got.d_voltage_command !== want.d_voltage_command)
			report("d_voltage_command", got.d_voltage_command, want.d_voltage_command);
		if (got.neutral_drive !== want.neutral_drive)
			report("neutral_drive", got.neutral_drive, want.neutral_drive);
		if (got.finished !== want.finished)
			report("finished", got.finished, want.finished);
		if (got.resistance !== want.resistance)
			report("resistance", got.resistance, want.resistance);
		if (got.divide_fault !== want.divide_fault)
			report("divide_fault", got.divide_fault, want.divide_fault);
		if (got.phase_code !== want.phase_code)
			report("phase_code", got.phase_code, want.phase_code);
		checked++;
	endtask
endclass

module motor_resistance_identifier_tb;
	import mri_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	mri_in_t             in_data;
	logic                out_valid;
	logic                out_stall;
	mri_out_t            out_data;
	logic                cfg_we;
	logic [IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0] cfg_data;

	tick_scoreboard sb;
	int idle_cycles;
	// random stimulus style: 0 tracks the sequence, 1 pure noise, 2 tracks with no idling
	int shape;
	longint amp;

	motor_resistance_identifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 0;
	always #2 clk = ~clk;

	// mostly short gaps, now and then a long one
	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// result side: random stall (none in style 2), check on every accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(out_data);
			if (shape == 2)
				out_stall <= 1'b0;
			else
				out_stall <= (gap_len() != 0);
		end
	end

	// watchdog on cycles where nothing moves
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
			$display("** motor_resistance_identifier: FAILED **");
			$finish;
		end
	end

	task write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.write_reg(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// send one request, holding it until the block takes it
	task send(logic signed [23:0] ia, logic signed [23:0] ib, logic signed [23:0] vm);
		int g;
		g = gap_len();
		if (shape == 2) g = 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data.current_alpha <= ia;
		in_data.current_beta <= ib;
		in_data.measured_d_voltage <= vm;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request('{ia, ib, vm});
	endtask

	task drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		// calc tick gives its result only; allow the block to settle
		repeat (100) @(posedge clk);
	endtask

	function logic signed [23:0] rnd24();
		return 24'($urandom());
	endfunction

	// plausible current: magnitude around amp plus noise
	task send_tracking();
		longint n, a, v;
		n = $urandom_range(0, 255);
		a = amp + $signed(n) - 128;
		v = amp / 2 + $signed({1'b0, 8'($urandom())}) - 128;
		if ($urandom_range(0, 1)) a = -a;
		send(24'(a), 24'($urandom_range(0, 2000)), 24'(v));
	endtask

	// one setting of the registers, then a run of ticks
	task phase_run(logic [22:0] sv, logic [15:0] st, logic [15:0] ht, logic [15:0] rs,
			logic [22:0] ct, logic [16:0] fg, int count, int sh, longint a);
		write_reg(REG_START_VOLTAGE, sv);
		write_reg(REG_START_TICKS, 23'(st));
		write_reg(REG_HOLD_TICKS, 23'(ht));
		write_reg(REG_RAMP_STEP, 23'(rs));
		write_reg(REG_CURRENT_TARGET, ct);
		write_reg(REG_FILTER_GAIN, 23'(fg));
		shape = sh;
		amp = a;
		for (int i = 0; i < count; i++) begin
			if (shape == 1 || $urandom_range(0, 9) == 0)
				send(rnd24(), rnd24(), rnd24());
			else
				send_tracking();
		end
		drain();
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_START_VOLTAGE;
		cfg_data = '0;
		shape = 0;
		amp = 65536;
		idle_cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, zero tick counts, gain of one, gain above one
		write_reg(REG_START_TICKS, 23'd0);
		write_reg(REG_HOLD_TICKS, 23'd0);
		write_reg(REG_FILTER_GAIN, 23'd65536);
		write_reg(REG_CURRENT_TARGET, 23'd1);
		send(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
		send(-24'sh800000, -24'sh800000, -24'sh800000);
		send(24'sh7FFFFF, -24'sh800000, 24'sd0);
		send(24'sd0, 24'sd0, 24'sd0);
		send(24'sd3, 24'sd4, -24'sd1);
		send(-24'sd1, 24'sd0, 24'sd1);
		send(24'sd0, 24'sd0, 24'sd0);
		send(24'sd0, 24'sd0, 24'sd0);
		// equal recorded currents: zero divisor
		for (int i = 0; i < 8; i++) send(24'sd100, 24'sd0, 24'sd0);
		drain();
		write_reg(REG_FILTER_GAIN, 23'h1FFFF);
		write_reg(REG_START_VOLTAGE, 23'h7FFFFF);
		for (int i = 0; i < 8; i++) send(rnd24(), rnd24(), rnd24());
		drain();

		// ramp overflow: huge step, target never reached, ramp saturates
		phase_run(23'h7FFFFF, 16'd1, 16'd1, 16'hFFFF, 23'h7FFFFF, 17'd0, 300, 0, 100);
		// full sequences with small tick counts and tracking currents
		phase_run(23'd131072, 16'd2, 16'd3, 16'd5000, 23'd20000, 17'd65536, 300, 0, 40000);
		phase_run(23'($urandom()), 16'd1, 16'd4, 16'($urandom_range(1, 65535)), 23'd30000,
			17'd40000, 250, 0, 60000);
		// no idling at all on either side
		phase_run(23'd0, 16'd3, 16'd2, 16'd1, 23'd0, 17'd3277, 120, 2, 1000);
		// pure noise
		phase_run(23'($urandom()), 16'd5, 16'd5, 16'd100, 23'($urandom()), 17'd65537, 150,
			1, 0);
		// tick limits at their maximum, other registers at their reset values
		phase_run(23'd131072, 16'hFFFF, 16'hFFFF, 16'd66, 23'd65536, 17'd3277, 40, 0, 65536);

		$display("checked %0d results; %0d completed sequences, %0d zero-divisor calcs",
			sb.checked, sb.done_count, sb.fault_count);
		$display("register extremes, zero and saturated counts, ramp overflow and noise covered");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("** motor_resistance_identifier: PASSED **");
		else
			$display("** motor_resistance_identifier: FAILED **");
		$finish;
	end
endmodule

FILE: filelist.f
hw/rtl/mri_pkg.sv
hw/rtl/mri_datapath.sv
hw/rtl/mri_controller.sv
hw/rtl/motor_resistance_identifier.sv
hw/rtl/mri_checker.sv
test/motor_resistance_identifier_tb.sv
